// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/bcc_pkg.sv =====
package bcc_pkg;

  // Field widths of the word formats
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned WINDOW_W   = 10;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Default module parameters
  localparam int unsigned TIME_WIDTH_DEF   = 32;
  localparam int unsigned SAMPLE_WIDTH_DEF = 12;

  // Fixed timings and reset values
  localparam logic [LONG_W-1:0]   REPEAT_DELAY_MS = 16'd700;
  localparam logic [LONG_W-1:0]   LONG_PRESS_RST  = 16'd1000;
  localparam logic [WINDOW_W-1:0] WINDOW_RST      = 10'd280;

  typedef enum logic [CMD_W-1:0] {
    CMD_POLL     = 2'd0,
    CMD_DEADLINE = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_RESYNC   = 2'd3
  } bcc_cmd_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } bcc_event_e;

  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_WINDOW     = 2'd1,
    REG_ACTIVE_LOW = 2'd2,
    REG_THRESHOLD  = 2'd3
  } bcc_reg_e;

  typedef struct packed {
    bcc_cmd_e           cmd;
    logic               level;
    logic [ADC_W-1:0]   analog_sample;
    logic [STAMP_W-1:0] now_ms;
    logic               auto_repeat;
    logic [STAMP_W-1:0] immediate_until;
    logic               suppress;
  } bcc_in_t;

  typedef struct packed {
    bcc_event_e event_res;
    logic       pressed;
  } bcc_out_t;

  typedef struct packed {
    logic [LONG_W-1:0]   long_press_ms;
    logic [WINDOW_W-1:0] click_gap_ms;
    logic                active_low;
    logic [ADC_W-1:0]    adc_threshold;
  } bcc_cfg_t;

endpackage

// ===== design/button_click_classifier.sv =====
// Channel   Direction  Handshake                Word
// -------   ---------  -----------------------  ---------------------------
// in        sink       in_valid_i / in_stall_o  bcc_in_t  (command, sample)
// out       source     out_valid_o / out_stall_i bcc_out_t (event, pressed)
// config    APB slave  psel/penable/pready      4 registers at 4*index
//
// One word per cycle while the output is not stalled: a word lands in the
// input register, is classified against the click state and moves into
// the result register, so out_valid_o rises once it reaches that register.
// Reset clears the click state, both valid flags and loads the register
// defaults. A stall on the output holds the result register, and the input
// register stalls only while it holds a word and the result cannot move.
`include "assert_macros.svh"

module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH   = TIME_WIDTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bcc_in_t               in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bcc_out_t              out_word_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_WIDTH) - 32'd1);

  bcc_cfg_t cfg;

  bcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control
  bcc_in_t  in_q;
  logic     in_vq;
  logic     out_vq;
  bcc_out_t out_q;
  logic     adv;
  logic     fire;

  assign adv        = !out_vq || !out_stall_i;
  assign fire       = in_vq && adv;
  assign in_stall_o = in_vq && !adv;

  // Click state
  logic          prev_q, prev_d;
  logic [TW-1:0] press_time_q, press_time_d;
  logic          press_valid_q, press_valid_d;
  logic          cancel_q, cancel_d;
  logic [1:0]    count_q, count_d;
  logic [TW-1:0] last_click_q, last_click_d;
  logic          pending_q, pending_d;
  logic [TW-1:0] deadline_q, deadline_d;
  bcc_out_t      res;

  // Classify the word in the input register
  always_comb begin
    logic [15:0]   smp;
    logic [15:0]   thr;
    logic          btn;
    logic          pr;
    logic [TW-1:0] now;
    logic [TW-1:0] dd;
    logic          immediate;
    logic          counts;
    bcc_event_e    ev;

    smp = 16'(in_q.analog_sample) & SMASK;
    thr = 16'(cfg.adc_threshold) & SMASK;
    now = TW'(64'(in_q.now_ms));
    if (thr != '0) begin
      btn = smp < thr;
      pr  = btn;
    end else begin
      btn = in_q.level;
      pr  = cfg.active_low ? !in_q.level : in_q.level;
    end

    prev_d        = prev_q;
    press_time_d  = press_time_q;
    press_valid_d = press_valid_q;
    cancel_d      = cancel_q;
    count_d       = count_q;
    last_click_d  = last_click_q;
    pending_d     = pending_q;
    deadline_d    = deadline_q;
    ev            = EV_NONE;
    dd            = deadline_q - now;
    immediate     = 1'b0;
    counts        = 1'b0;

    case (in_q.cmd)
      CMD_DEADLINE: begin
        deadline_d = TW'(64'(in_q.immediate_until));
      end
      CMD_CANCEL: begin
        cancel_d      = 1'b1;
        press_valid_d = 1'b0;
        press_time_d  = '0;
        count_d       = '0;
        last_click_d  = '0;
        pending_d     = 1'b0;
      end
      CMD_RESYNC: begin
        prev_d        = btn;
        cancel_d      = in_q.suppress;
        press_valid_d = !in_q.suppress && pr;
        press_time_d  = press_valid_d ? now : '0;
        count_d       = '0;
        last_click_d  = '0;
        pending_d     = 1'b0;
      end
      default: begin
        // Press or release edge
        if (btn != prev_q) begin
          if (pr) begin
            press_time_d  = now;
            press_valid_d = 1'b1;
          end else begin
            immediate = (cfg.click_gap_ms == '0) ||
                        (deadline_q != '0 && dd != '0 && !dd[TW-1]);
            counts    = (cfg.long_press_ms == '0) ||
                        (press_valid_q &&
                         ((now - press_time_q) < TW'(cfg.long_press_ms)));
            if (counts) begin
              if (immediate) begin
                if (!cancel_q) begin
                  ev         = EV_CLICK;
                  deadline_d = '0;
                end
                count_d      = '0;
                last_click_d = '0;
                pending_d    = 1'b0;
              end else begin
                if (count_q != 2'd3) count_d = count_q + 2'd1;
                last_click_d = now;
                pending_d    = 1'b1;
              end
            end
            press_valid_d = 1'b0;
            press_time_d  = '0;
          end
          prev_d = btn;
        end
        if (!pr) cancel_d = 1'b0;

        // Long press, dropped when clicks are still pending
        if (cfg.long_press_ms != '0 && press_valid_d &&
            (now - press_time_d) >= TW'(cfg.long_press_ms)) begin
          if (pending_d) begin
            cancel_d = 1'b1;
          end else begin
            ev = EV_LONG;
          end
          press_valid_d = 1'b0;
          press_time_d  = '0;
          count_d       = '0;
          last_click_d  = '0;
          pending_d     = 1'b0;
        end

        // Auto-repeat while held
        if (press_valid_d && in_q.auto_repeat &&
            (now - press_time_d) >= TW'(REPEAT_DELAY_MS)) begin
          ev = EV_CLICK;
        end

        // Close the multi-click window
        if (pending_d && !press_valid_d &&
            (now - last_click_d) >= TW'(cfg.click_gap_ms)) begin
          ev           = (count_d == 2'd0) ? EV_TRIPLE : bcc_event_e'(EVENT_W'(count_d));
          count_d      = '0;
          last_click_d = '0;
          pending_d    = 1'b0;
        end
      end
    endcase

    res.event_res = ev;
    res.pressed   = pr;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (!in_stall_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  // Advance click state on each classified word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= 1'b0;
      press_time_q  <= '0;
      press_valid_q <= 1'b0;
      cancel_q      <= 1'b0;
      count_q       <= '0;
      last_click_q  <= '0;
      pending_q     <= 1'b0;
      deadline_q    <= '0;
    end else if (fire) begin
      prev_q        <= prev_d;
      press_time_q  <= press_time_d;
      press_valid_q <= press_valid_d;
      cancel_q      <= cancel_d;
      count_q       <= count_d;
      last_click_q  <= last_click_d;
      pending_q     <= pending_d;
      deadline_q    <= deadline_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= in_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vq;
  assign out_word_o  = out_q;

  `BCC_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `BCC_ASSERT(a_count_pending, (count_q != 2'd0) == pending_q, "count without pending")
  `BCC_ASSERT(a_press_time_clear, press_valid_q || (press_time_q == '0), "stale press time")
  `BCC_ASSERT(a_stall_cause, in_stall_o |-> (out_vq && out_stall_i), "needless input stall")
  `BCC_ASSERT(a_fire_lands, fire |=> out_vq, "word lost before result register")

endmodule

// ===== design/bcc_cfg.sv =====
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output bcc_cfg_t              cfg_o
);

  bcc_cfg_t cfg_q;
  bcc_reg_e sel;
  logic     wr_en;

  assign pready = 1'b1;
  assign sel    = bcc_reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= LONG_PRESS_RST;
      cfg_q.click_gap_ms  <= WINDOW_RST;
      cfg_q.active_low    <= 1'b0;
      cfg_q.adc_threshold <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[LONG_W-1:0];
        REG_WINDOW:     cfg_q.click_gap_ms  <= pwdata[WINDOW_W-1:0];
        REG_ACTIVE_LOW: cfg_q.active_low    <= pwdata[0];
        REG_THRESHOLD:  cfg_q.adc_threshold <= pwdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (sel)
      REG_LONG_PRESS: prdata = APB_DATA_W'(cfg_q.long_press_ms);
      REG_WINDOW:     prdata = APB_DATA_W'(cfg_q.click_gap_ms);
      REG_ACTIVE_LOW: prdata = APB_DATA_W'(cfg_q.active_low);
      REG_THRESHOLD:  prdata = APB_DATA_W'(cfg_q.adc_threshold);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
